// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the bracket checker; included by bbc_back.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BBC_ASSERT(lbl, prop, msg)
`define BBC_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== design/bbc_pkg.sv =====
// ---------------------------------------------------------------------------
// bbc_pkg
// Types, widths and codes shared by the bracket balance checker.
// ---------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;
  localparam int OP_W   = 2;
  localparam int VERD_W = 3;

  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  localparam logic [KIND_W-1:0] KIND_PAREN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BRACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BRACE = 2'd2;

  localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
  localparam logic [OP_W-1:0] OP_OPEN  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;

  localparam logic [VERD_W-1:0] VERD_BALANCED   = 3'd0;
  localparam logic [VERD_W-1:0] VERD_EXTRA_CLOSE = 3'd1;
  localparam logic [VERD_W-1:0] VERD_MISMATCH   = 3'd2;
  localparam logic [VERD_W-1:0] VERD_EXTRA_OPEN = 3'd3;
  localparam logic [VERD_W-1:0] VERD_OVERFLOW   = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic [CHAR_W-1:0] open_char;
    logic [CHAR_W-1:0] close_char;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } cls_item_t;

  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } q_head_t;

  function automatic logic [CHAR_W-1:0] open_char_of(input logic [KIND_W-1:0] kind);
    logic [CHAR_W-1:0] c;
    case (kind)
      KIND_BRACK: c = CH_LBRACK;
      KIND_BRACE: c = CH_LBRACE;
      default:    c = CH_LPAREN;
    endcase
    return c;
  endfunction

endpackage

// ===== design/bbc_front.sv =====
// ---------------------------------------------------------------------------
// bbc_front
// Accepts input items and classifies each byte as opener, closer or other.
// ---------------------------------------------------------------------------
module bbc_front (
  input  logic              in_valid,
  input  bbc_pkg::in_item_t in_item,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output bbc_pkg::cls_item_t q_item
);

  always_comb begin
    q_item.ch   = in_item.char_in;
    q_item.last = in_item.last;
    q_item.op   = bbc_pkg::OP_NONE;
    q_item.kind = bbc_pkg::KIND_PAREN;
    case (in_item.char_in)
      bbc_pkg::CH_LPAREN: begin
        q_item.op   = bbc_pkg::OP_OPEN;
        q_item.kind = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CH_LBRACK: begin
        q_item.op   = bbc_pkg::OP_OPEN;
        q_item.kind = bbc_pkg::KIND_BRACK;
      end
      bbc_pkg::CH_LBRACE: begin
        q_item.op   = bbc_pkg::OP_OPEN;
        q_item.kind = bbc_pkg::KIND_BRACE;
      end
      bbc_pkg::CH_RPAREN: begin
        q_item.op   = bbc_pkg::OP_CLOSE;
        q_item.kind = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CH_RBRACK: begin
        q_item.op   = bbc_pkg::OP_CLOSE;
        q_item.kind = bbc_pkg::KIND_BRACK;
      end
      bbc_pkg::CH_RBRACE: begin
        q_item.op   = bbc_pkg::OP_CLOSE;
        q_item.kind = bbc_pkg::KIND_BRACE;
      end
      default: begin
        q_item.op   = bbc_pkg::OP_NONE;
        q_item.kind = bbc_pkg::KIND_PAREN;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== design/bbc_queue.sv =====
// ---------------------------------------------------------------------------
// bbc_queue
// Short queue of classified items between front and back.
// ---------------------------------------------------------------------------
module bbc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bbc_pkg::cls_item_t push_item,
  output logic               full,
  input  logic               pop,
  output bbc_pkg::q_head_t   head
);

  bbc_pkg::cls_item_t              ent_r [bbc_pkg::QUEUE_DEPTH];
  logic [bbc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [bbc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [bbc_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == bbc_pkg::QCNT_W'(bbc_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bbc_pkg::QPTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + bbc_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bbc_pkg::QPTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + bbc_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + bbc_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - bbc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/bbc_back.sv =====
// ---------------------------------------------------------------------------
// bbc_back
// Runs the bracket stack, keeps the first error and forms the verdict.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bbc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bbc_pkg::q_head_t   head,
  output logic               q_pop,
  output logic               out_valid,
  output bbc_pkg::out_item_t out_item,
  input  logic               out_stall
);

  // top of stack lives in top_r; entries below it sit in the memory
  logic [bbc_pkg::KIND_W-1:0] stack_mem [bbc_pkg::STACK_DEPTH];

  logic [bbc_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bbc_pkg::KIND_W-1:0] top_r, top_nxt;
  logic [bbc_pkg::KIND_W-1:0] below_r, below_nxt;
  logic [bbc_pkg::KIND_W-1:0] mem_q_r;
  logic                       use_mem_r, use_mem_nxt;
  logic [bbc_pkg::VERD_W-1:0] err_r, err_nxt;
  logic [bbc_pkg::CHAR_W-1:0] bad_open_r, bad_open_nxt;
  logic [bbc_pkg::CHAR_W-1:0] bad_close_r, bad_close_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bbc_pkg::out_item_t         out_item_r, out_item_nxt;

  logic                       go;
  logic [bbc_pkg::KIND_W-1:0] below;
  logic                       wr_en, rd_en;
  logic [bbc_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [bbc_pkg::CNT_W-1:0]  cnt_m1, cnt_m3;
  logic [bbc_pkg::VERD_W-1:0] verd;

  assign go    = head.valid && (!head.item.last || !out_valid_r || !out_stall);
  assign q_pop = go;
  assign below = use_mem_r ? mem_q_r : below_r;

  assign cnt_m1  = count_r - bbc_pkg::CNT_W'(1);
  assign cnt_m3  = count_r - bbc_pkg::CNT_W'(3);
  assign wr_addr = cnt_m1[bbc_pkg::ADDR_W-1:0];
  assign rd_addr = cnt_m3[bbc_pkg::ADDR_W-1:0];

  always_comb begin
    count_nxt     = count_r;
    top_nxt       = top_r;
    below_nxt     = below;
    use_mem_nxt   = 1'b0;
    err_nxt       = err_r;
    bad_open_nxt  = bad_open_r;
    bad_close_nxt = bad_close_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    verd          = bbc_pkg::VERD_BALANCED;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (go && (err_r == bbc_pkg::VERD_BALANCED)) begin
      case (head.item.op)
        bbc_pkg::OP_OPEN: begin
          if (count_r == bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH)) begin
            err_nxt = bbc_pkg::VERD_OVERFLOW;
          end else begin
            wr_en     = (count_r != '0);
            below_nxt = top_r;
            top_nxt   = head.item.kind;
            count_nxt = count_r + bbc_pkg::CNT_W'(1);
          end
        end
        bbc_pkg::OP_CLOSE: begin
          if (count_r == '0) begin
            err_nxt = bbc_pkg::VERD_EXTRA_CLOSE;
          end else begin
            count_nxt   = cnt_m1;
            top_nxt     = below;
            rd_en       = 1'b1;
            use_mem_nxt = 1'b1;
            if (top_r != head.item.kind) begin
              err_nxt       = bbc_pkg::VERD_MISMATCH;
              bad_open_nxt  = bbc_pkg::open_char_of(top_r);
              bad_close_nxt = head.item.ch;
            end
          end
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end

    if (go && head.item.last) begin
      verd = err_nxt;
      if ((err_nxt == bbc_pkg::VERD_BALANCED) && (count_nxt != '0)) begin
        verd = bbc_pkg::VERD_EXTRA_OPEN;
      end
      out_valid_nxt           = 1'b1;
      out_item_nxt.verdict    = verd;
      out_item_nxt.open_char  = (verd == bbc_pkg::VERD_MISMATCH) ? bad_open_nxt : '0;
      out_item_nxt.close_char = (verd == bbc_pkg::VERD_MISMATCH) ? bad_close_nxt : '0;
      count_nxt               = '0;
      err_nxt                 = bbc_pkg::VERD_BALANCED;
      bad_open_nxt            = '0;
      bad_close_nxt           = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= bbc_pkg::VERD_BALANCED;
      bad_open_r  <= '0;
      bad_close_r <= '0;
      use_mem_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      bad_open_r  <= bad_open_nxt;
      bad_close_r <= bad_close_nxt;
      use_mem_r   <= use_mem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    below_r    <= below_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= top_r;
    end
    if (rd_en) begin
      mem_q_r <= stack_mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `BBC_ASSERT(a_count_bound, count_r <= bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH), "stack count beyond depth")
  `BBC_ASSERT_IMP(a_bad_clear, err_r != bbc_pkg::VERD_MISMATCH, (bad_open_r == '0) && (bad_close_r == '0), "kept characters without mismatch")
  `BBC_ASSERT_IMP(a_out_chars, out_valid_r && (out_item_r.verdict != bbc_pkg::VERD_MISMATCH), (out_item_r.open_char == '0) && (out_item_r.close_char == '0), "characters on a non-mismatch verdict")

endmodule

// ===== design/bracket_balance_checker.sv =====
// ---------------------------------------------------------------------------
// bracket_balance_checker
// Balanced-bracket check over a byte stream, one verdict per expression.
//
//   channel  ports                          direction  carries
//   input    in_valid  in_stall  in_item    in         char_in, last
//   result   out_valid out_stall out_item   out        verdict, open_char, close_char
//
// One item per cycle while no stall holds the flow; the stack keeps its top in a
// register and prefetches the entry below it from the stack memory, so pops may
// follow each other in consecutive cycles.
// A verdict is registered once its last item has passed through the queue to the back end.
// Reset is synchronous and clears all control state; no clearing pass.
// A stall on the result side only holds back items that carry the last flag.
// ---------------------------------------------------------------------------
module bracket_balance_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bbc_pkg::in_item_t  in_item,
  output logic               in_stall,
  output logic               out_valid,
  output bbc_pkg::out_item_t out_item,
  input  logic               out_stall
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  bbc_pkg::cls_item_t q_item;
  bbc_pkg::q_head_t   q_head;

  bbc_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  bbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  bbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
